FILE: rtl/wlqe_pkg.sv
// ----------------------------------------------------------------------------
// wlqe_pkg
// Shared widths, constants and types of the wide line quad expander.
// ----------------------------------------------------------------------------
package wlqe_pkg;

	localparam int COORD_W = 24;
	localparam int WIDTH_W = 23;
	localparam int DELTA_W = COORD_W + 1;
	localparam int SQR_W   = 2 * DELTA_W - 1;   // one square, unsigned
	localparam int SUM_W   = SQR_W + 1;
	localparam int RAD_W   = SUM_W + 12;        // radicand, sum scaled by 4096
	localparam int ROOT_W  = RAD_W / 2;
	localparam int QUO_W   = 17;                // quotient never exceeds 65536
	localparam int NUM_W   = ROOT_W + QUO_W - 1;
	localparam int DIR_W   = QUO_W + 1;
	localparam int PROD_W  = WIDTH_W + 1 + DIR_W;
	localparam int OFS_W   = COORD_W + 1;
	localparam int SUM3_W  = COORD_W + 3;

	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES  = QUO_W;

	localparam logic signed [DIR_W-1:0]  DIR_ONE = 18'sd65536;
	localparam logic signed [COORD_W-1:0] SAT_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] SAT_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
		logic [WIDTH_W-1:0]        w;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic                      zero;
	} seg_t;

endpackage

FILE: rtl/wlqe_isqrt.sv
// ----------------------------------------------------------------------------
// wlqe_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module wlqe_isqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [wlqe_pkg::RAD_W-1:0]  rad,
	output logic [wlqe_pkg::ROOT_W-1:0] root
);
	import wlqe_pkg::*;

	logic [RAD_W-1:0]  rem_s  [0:SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [0:SQRT_STAGES];

	assign rem_s[0]  = rad;
	assign root_s[0] = '0;

	// The remainder holds rad minus root squared; each stage tries one more bit.
	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam int I = ROOT_W - 1 - k;
		logic [RAD_W:0] trial;
		logic           take;

		assign trial = ({{(RAD_W+1-ROOT_W){1'b0}}, root_s[k]} << (I + 1))
			| ((RAD_W+1)'(1) << (2 * I));
		assign take = {1'b0, rem_s[k]} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial[RAD_W-1:0] : rem_s[k];
				root_s[k+1] <= take ? (root_s[k] | (ROOT_W'(1) << I)) : root_s[k];
			end
		end
	end

	assign root = root_s[SQRT_STAGES];

endmodule

FILE: rtl/wlqe_div.sv
// ----------------------------------------------------------------------------
// wlqe_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module wlqe_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [wlqe_pkg::NUM_W-1:0]  num,
	input  logic [wlqe_pkg::ROOT_W-1:0] den,
	output logic [wlqe_pkg::QUO_W-1:0]  quo
);
	import wlqe_pkg::*;

	logic [NUM_W-1:0]  rem_s [0:DIV_STAGES];
	logic [ROOT_W-1:0] den_s [0:DIV_STAGES];
	logic [QUO_W-1:0]  quo_s [0:DIV_STAGES];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam int I = QUO_W - 1 - k;
		logic [NUM_W-1:0] trial;
		logic             take;

		assign trial = {{(NUM_W-ROOT_W){1'b0}}, den_s[k]} << I;
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - trial : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= take ? (quo_s[k] | (QUO_W'(1) << I)) : quo_s[k];
			end
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule

FILE: rtl/wide_line_quad_expander.sv
// ----------------------------------------------------------------------------
// wide_line_quad_expander
// Expands a line segment and a width into the four corners of its quad.
// Throughput: one item per cycle while the skid entry is empty; the square root
// (31 stages) and the two dividers (17 stages each) are fully pipelined, one bit
// per stage.
// A two-entry output register and skid stage hold results while the sink stalls.
// Reset clears all valid bits and the skid state; data registers are not reset.
// ----------------------------------------------------------------------------
module wide_line_quad_expander (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// start_x, start_y, end_x, end_y, line_width, one zero pad bit
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
	// corner3_x, corner3_y
	output logic [191:0] m_axis_tdata
);
	import wlqe_pkg::*;

	logic en;
	logic skid_v_q, out_v_q;
	logic [191:0] out_q, skid_q;

	assign en            = ~skid_v_q;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	// Front: register, differences, squares, radicand.
	logic v_s1, v_s2, v_s3, v_s4;
	seg_t seg_s1, seg_s2, seg_s3, seg_s4;
	logic [SQR_W-1:0] dx2_s3, dy2_s3;
	logic [RAD_W-1:0] rad_s4;
	logic signed [2*DELTA_W-1:0] dx2_c, dy2_c;
	logic [SUM_W-1:0] sum_c;

	assign dx2_c = seg_s2.dx * seg_s2.dx;
	assign dy2_c = seg_s2.dy * seg_s2.dy;
	assign sum_c = {1'b0, dx2_s3} + {1'b0, dy2_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1.sx   <= s_axis_tdata[23:0];
			seg_s1.sy   <= s_axis_tdata[47:24];
			seg_s1.ex   <= s_axis_tdata[71:48];
			seg_s1.ey   <= s_axis_tdata[95:72];
			seg_s1.w    <= s_axis_tdata[118:96];
			seg_s1.dx   <= '0;
			seg_s1.dy   <= '0;
			seg_s1.zero <= 1'b0;

			seg_s2.sx   <= seg_s1.sx;
			seg_s2.sy   <= seg_s1.sy;
			seg_s2.ex   <= seg_s1.ex;
			seg_s2.ey   <= seg_s1.ey;
			seg_s2.w    <= seg_s1.w;
			seg_s2.dx   <= DELTA_W'(seg_s1.ex) - DELTA_W'(seg_s1.sx);
			seg_s2.dy   <= DELTA_W'(seg_s1.ey) - DELTA_W'(seg_s1.sy);
			seg_s2.zero <= seg_s1.zero;

			seg_s3 <= seg_s2;
			dx2_s3 <= dx2_c[SQR_W-1:0];
			dy2_s3 <= dy2_c[SQR_W-1:0];

			seg_s4.sx   <= seg_s3.sx;
			seg_s4.sy   <= seg_s3.sy;
			seg_s4.ex   <= seg_s3.ex;
			seg_s4.ey   <= seg_s3.ey;
			seg_s4.w    <= seg_s3.w;
			seg_s4.dx   <= seg_s3.dx;
			seg_s4.dy   <= seg_s3.dy;
			seg_s4.zero <= sum_c == '0;
			rad_s4      <= {sum_c, 12'b0};
		end
	end

	// Square root, with the segment carried alongside.
	logic [ROOT_W-1:0] root;
	logic [SQRT_STAGES:1] v_sq;
	seg_t seg_sq [1:SQRT_STAGES];

	wlqe_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s4),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			seg_sq[1] <= seg_s4;
			for (int k = 2; k <= SQRT_STAGES; k++) seg_sq[k] <= seg_sq[k-1];
		end
	end

	// Numerators: magnitude times 2^22 plus half the root, for rounding.
	logic v_s5;
	seg_t seg_s5;
	logic [NUM_W-1:0] num_x_s5, num_y_s5;
	logic [ROOT_W-1:0] root_s5;
	logic [DELTA_W-1:0] mag_x_c, mag_y_c;
	seg_t seg_last_sq;

	assign seg_last_sq = seg_sq[SQRT_STAGES];
	assign mag_x_c = seg_last_sq.dx[DELTA_W-1] ? DELTA_W'(-seg_last_sq.dx) : seg_last_sq.dx;
	assign mag_y_c = seg_last_sq.dy[DELTA_W-1] ? DELTA_W'(-seg_last_sq.dy) : seg_last_sq.dy;

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s5   <= seg_last_sq;
			root_s5  <= root;
			num_x_s5 <= {mag_x_c, 22'b0} + {{(NUM_W-ROOT_W+1){1'b0}}, root[ROOT_W-1:1]};
			num_y_s5 <= {mag_y_c, 22'b0} + {{(NUM_W-ROOT_W+1){1'b0}}, root[ROOT_W-1:1]};
		end
	end

	// Two dividers give cos and sin magnitudes.
	logic [QUO_W-1:0] quo_x, quo_y;
	logic [DIV_STAGES:1] v_dv;
	seg_t seg_dv [1:DIV_STAGES];

	wlqe_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (num_x_s5),
		.den (root_s5),
		.quo (quo_x)
	);

	wlqe_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (num_y_s5),
		.den (root_s5),
		.quo (quo_y)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			seg_dv[1] <= seg_s5;
			for (int k = 2; k <= DIV_STAGES; k++) seg_dv[k] <= seg_dv[k-1];
		end
	end

	// Direction, products, rounding.
	logic v_s6, v_s7, v_s8;
	seg_t seg_s6, seg_s7, seg_s8;
	logic signed [DIR_W-1:0] c_s6, s_s6;
	logic signed [PROD_W-1:0] px_s7, py_s7;
	logic signed [OFS_W-1:0] wx_s8, wy_s8;
	seg_t seg_last_dv;
	logic signed [DIR_W-1:0] cq_c, sq_c;
	logic [PROD_W-2:0] pmx_c, pmy_c;
	logic [PROD_W-1:0] rx_c, ry_c;

	assign seg_last_dv = seg_dv[DIV_STAGES];
	assign cq_c = seg_last_dv.dx[DELTA_W-1] ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
	assign sq_c = seg_last_dv.dy[DELTA_W-1] ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});

	assign pmx_c = px_s7[PROD_W-1] ? (PROD_W-1)'(-px_s7) : px_s7[PROD_W-2:0];
	assign pmy_c = py_s7[PROD_W-1] ? (PROD_W-1)'(-py_s7) : py_s7[PROD_W-2:0];
	assign rx_c  = ({1'b0, pmx_c} + (PROD_W'(1) << 16)) >> 17;
	assign ry_c  = ({1'b0, pmy_c} + (PROD_W'(1) << 16)) >> 17;

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s6 <= seg_last_dv;
			c_s6   <= seg_last_dv.zero ? DIR_ONE : cq_c;
			s_s6   <= seg_last_dv.zero ? '0 : sq_c;

			seg_s7 <= seg_s6;
			px_s7  <= $signed({1'b0, seg_s6.w}) * s_s6;
			py_s7  <= $signed({1'b0, seg_s6.w}) * c_s6;

			seg_s8 <= seg_s7;
			wx_s8  <= px_s7[PROD_W-1] ? -$signed(rx_c[OFS_W-1:0]) : $signed(rx_c[OFS_W-1:0]);
			wy_s8  <= py_s7[PROD_W-1] ? -$signed(ry_c[OFS_W-1:0]) : $signed(ry_c[OFS_W-1:0]);
		end
	end

	// Corners with saturation.
	function automatic logic [COORD_W-1:0] sat3(
		input logic signed [COORD_W-1:0] b,
		input logic signed [OFS_W-1:0]   p,
		input logic signed [OFS_W-1:0]   q
	);
		logic signed [SUM3_W-1:0] t;
		t = SUM3_W'(b) + SUM3_W'(p) + SUM3_W'(q);
		if (t > SUM3_W'(SAT_MAX)) return SAT_MAX;
		if (t < SUM3_W'(SAT_MIN)) return SAT_MIN;
		return t[COORD_W-1:0];
	endfunction

	logic [191:0] corners_c;

	assign corners_c = {
		sat3(seg_s8.sy,  wy_s8, -wx_s8),
		sat3(seg_s8.sx, -wx_s8, -wy_s8),
		sat3(seg_s8.ey,  wy_s8,  wx_s8),
		sat3(seg_s8.ex, -wx_s8,  wy_s8),
		sat3(seg_s8.ey, -wy_s8,  wx_s8),
		sat3(seg_s8.ex,  wx_s8,  wy_s8),
		sat3(seg_s8.sy, -wy_s8, -wx_s8),
		sat3(seg_s8.sx,  wx_s8, -wy_s8)
	};

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_sq <= '0;
			v_s5 <= 1'b0;
			v_dv <= '0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sq <= {v_sq[SQRT_STAGES-1:1], v_s4};
			v_s5 <= v_sq[SQRT_STAGES];
			v_dv <= {v_dv[DIV_STAGES-1:1], v_s5};
			v_s6 <= v_dv[DIV_STAGES];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s8;
			end
		end else if (v_s8 && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_q <= skid_v_q ? skid_q : corners_c;
		end else if (v_s8 && en) begin
			skid_q <= corners_c;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds an item while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
		else $error("skid entry filled without an output stall");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (c_s6 <= DIR_ONE && c_s6 >= -DIR_ONE && s_s6 <= DIR_ONE && s_s6 >= -DIR_ONE))
		else $error("direction component outside the unit range");

endmodule

FILE: dv/wlqe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlqe_checker
// Watches both streams of the quad expander, computes the expected corners of
// each accepted segment and compares them with the results in order.
// ----------------------------------------------------------------------------
module wlqe_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [191:0] m_axis_tdata,
	output int           fail_count,
	output int           pending
);
	import wlqe_pkg::*;

	logic [191:0] corner_queue[$];

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n = n - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// Rounds to nearest with halves away from zero.
	function automatic longint div_nearest(longint n, longint d);
		longint mag;
		mag = (n < 0) ? -n : n;
		mag = (mag + (d >>> 1)) / d;
		return (n < 0) ? -mag : mag;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > 65536)
			return 65536;
		if (v < -65536)
			return -65536;
		return v;
	endfunction

	function automatic logic [23:0] clip24(longint v);
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[23:0];
	endfunction

	function automatic logic [191:0] quad_corners(logic [119:0] seg);
		logic signed [COORD_W-1:0] sx, sy, ex, ey;
		longint w, dx, dy, cs, sn, wx, wy;
		longint unsigned sq, q;
		sx = seg[23:0];
		sy = seg[47:24];
		ex = seg[71:48];
		ey = seg[95:72];
		w  = longint'(seg[118:96]);
		dx = longint'(ex) - longint'(sx);
		dy = longint'(ey) - longint'(sy);
		sq = dx * dx + dy * dy;
		if (sq == 0) begin
			cs = 65536;
			sn = 0;
		end else begin
			q = int_sqrt(sq << 12);
			cs = clamp_unit(div_nearest(dx * (64'sd1 << 22), longint'(q)));
			sn = clamp_unit(div_nearest(dy * (64'sd1 << 22), longint'(q)));
		end
		wx = div_nearest(w * sn, 64'sd1 << 17);
		wy = div_nearest(w * cs, 64'sd1 << 17);
		return {clip24(sy + wy - wx), clip24(sx - wx - wy),
			clip24(ey + wy + wx), clip24(ex - wx + wy),
			clip24(ey - wy + wx), clip24(ex + wx + wy),
			clip24(sy - wy - wx), clip24(sx + wx - wy)};
	endfunction

	assign pending = corner_queue.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		logic [191:0] want;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			corner_queue.push_back(quad_corners(s_axis_tdata));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (corner_queue.size() == 0) begin
				fail_count++;
				$display("%t: unexpected result %h", $time, m_axis_tdata);
			end else begin
				want = corner_queue.pop_front();
				for (int i = 0; i < 8; i++)
					if (want[i*24 +: 24] !== m_axis_tdata[i*24 +: 24]) begin
						fail_count++;
						$display("%t: corner field %0d expected %h actual %h",
							$time, i, want[i*24 +: 24], m_axis_tdata[i*24 +: 24]);
					end
			end
		end
	end

endmodule

FILE: dv/tb_wide_line_quad_expander.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wide_line_quad_expander
// Drives directed and random segments with bursty input and a stalling sink;
// the checker predicts and compares every quad.
// ----------------------------------------------------------------------------
module tb_wide_line_quad_expander;
	import wlqe_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [191:0] m_axis_tdata;
	int           fail_count;
	int           pending;
	int           cycle_count;
	bit           hold_sink;

	wide_line_quad_expander dut (.*);

	wlqe_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		hold_sink = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sink stall pattern, with a long hold-off when asked.
	always @(posedge clk) begin
		if (hold_sink)
			m_axis_tready <= 1'b0;
		else if (cycle_count % 600 < 150)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 200000) begin
			$display("wide_line_quad_expander test failed");
			$finish;
		end
	end

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 24'(24'h800000 + $urandom_range(0, 3));
			1: return 24'(24'h7FFFFF - $urandom_range(0, 3));
			2: return 24'($urandom_range(0, 4000) - 2000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [22:0] rand_width();
		case ($urandom_range(0, 3))
			0: return 23'h7FFFFF;
			1: return 23'($urandom_range(0, 3));
			default: return 23'($urandom);
		endcase
	endfunction

	task automatic send_segment(logic [23:0] sx, logic [23:0] sy, logic [23:0] ex,
		logic [23:0] ey, logic [22:0] w);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, w, ey, ex, sy, sx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic [23:0] sx, sy;
		sx = rand_coord();
		sy = rand_coord();
		if ($urandom_range(0, 7) == 0)
			send_segment(sx, sy, sx, sy, rand_width());
		else if ($urandom_range(0, 3) == 0)
			send_segment(sx, sy, 24'(sx + $urandom_range(0, 8) - 4),
				24'(sy + $urandom_range(0, 8) - 4), rand_width());
		else
			send_segment(sx, sy, rand_coord(), rand_coord(), rand_width());
	endtask

	task automatic idle_gap();
		int n;
		n = $urandom_range(1, 6);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int burst;
		@(posedge arst_n);
		@(posedge clk);
		// Directed: zero length, axis directions, diagonals, extremes, saturation.
		send_segment(24'd0, 24'd0, 24'd0, 24'd0, 23'd512);
		send_segment(24'h001000, 24'hFFF000, 24'h001000, 24'hFFF000, 23'h7FFFFF);
		send_segment(24'd0, 24'd0, 24'd256, 24'd0, 23'd256);
		send_segment(24'd0, 24'd0, -24'd256, 24'd0, 23'd256);
		send_segment(24'd0, 24'd0, 24'd0, 24'd256, 23'd256);
		send_segment(24'd0, 24'd0, 24'd0, -24'd256, 23'd256);
		send_segment(24'd0, 24'd0, 24'd100, 24'd100, 23'd1000);
		send_segment(24'd0, 24'd0, 24'd1, 24'd0, 23'd1);
		send_segment(24'd0, 24'd0, 24'd1, 24'd1, 23'd3);
		send_segment(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF);
		send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 23'h7FFFFF);
		send_segment(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 23'h7FFFFF);
		send_segment(24'h7FFFFF, 24'h000000, 24'h7FFFFF, 24'h000100, 23'h7FFFFF);
		send_segment(24'h800000, 24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF);
		send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF);
		send_segment(24'h123456, 24'h654321, 24'h555555, 24'hAAAAAA, 23'h2AAAAA);
		send_segment(24'hAAAAAA, 24'h555555, 24'h123456, 24'hFEDCBA, 23'h555555);
		send_segment(24'd0, 24'd0, 24'd3, 24'd4, 23'd0);

		// Sender pauses until every quad has come back.
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);

		// Long sink hold-off while the source keeps offering segments.
		hold_sink <= 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_sink <= 1'b0;
			end
			repeat (120) send_random();
		join

		for (int i = 0; i < 280; i += burst) begin
			burst = $urandom_range(1, 30);
			repeat (burst) send_random();
			if ($urandom_range(0, 2) != 0)
				idle_gap();
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("wide_line_quad_expander test passed");
		else
			$display("wide_line_quad_expander test failed");
		$finish;
	end

endmodule
